FILE: rtl/core/chm_pkg.sv
// ============================================================================
// chm_pkg
// Shared types and constants for the monotone chain convex hull block.
// ============================================================================
package chm_pkg;

    // Default sizes handed down from the top level.
    localparam int MAX_POINTS_DEF = 64;
    localparam int COORD_BITS_DEF = 16;

    // Commands from the controller to the datapath, one per cycle.
    typedef enum logic [5:0] {
        OP_NONE,
        OP_LOAD,
        OP_S_INIT,
        OP_S_RDI,
        OP_S_LDV,
        OP_S_RDJ,
        OP_S_SHIFT,
        OP_S_PUTV,
        OP_H_RD0,
        OP_H_RDN,
        OP_H_LDN,
        OP_H_INIT,
        OP_H_RDI,
        OP_H_SIDE,
        OP_T_D,
        OP_T_M1,
        OP_T_M2,
        OP_H_FLAGS,
        OP_U_STK,
        OP_L_STK,
        OP_C_RD1,
        OP_C_RD2,
        OP_C_RD3,
        OP_U_POP,
        OP_U_PUSH,
        OP_L_POP,
        OP_L_PUSH,
        OP_H_NEXT,
        OP_O_INITU,
        OP_O_STKU,
        OP_O_STKL,
        OP_O_EMITU,
        OP_O_EMITL,
        OP_O_NEXTU,
        OP_O_INITL,
        OP_O_NEXTL,
        OP_O_EMIT1,
        OP_DONE
    } t_op;

    // Status flags from the datapath back to the controller.
    typedef struct packed {
        logic acc_last;
        logic i_eq_n;
        logic i_is_end;
        logic j_zero;
        logic v_before;
        logic trivial;
        logic do_u;
        logic do_l;
        logic nu_ge2;
        logic nl_ge2;
        logic nl_ge3;
        logic turn_pos;
        logic turn_neg;
        logic k_u_end;
        logic k_l_end;
        logic out_busy;
    } t_stat;

endpackage

FILE: rtl/core/chm_ctrl.sv
// ============================================================================
// chm_ctrl
// Sequencer for loading, insertion sort, both chain passes and vertex output.
// ============================================================================
module chm_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  chm_pkg::t_stat i_stat,
    output chm_pkg::t_op   o_op
);

    typedef enum logic [5:0] {
        ST_LOAD, ST_SINIT, ST_SI, ST_SV, ST_SR, ST_SC, ST_SW,
        ST_H0, ST_H1, ST_H2, ST_HC, ST_HI, ST_HS, ST_HF,
        ST_TD, ST_TM1, ST_TM2,
        ST_CR1, ST_CR2, ST_CR3,
        ST_UC, ST_UT, ST_UP, ST_LC, ST_LT, ST_LP, ST_HN,
        ST_OU0, ST_OUS, ST_OUR, ST_OUE, ST_OUW,
        ST_OL0, ST_OLS, ST_OLR, ST_OLE, ST_OLW,
        ST_OW1, ST_DONE
    } t_state;

    t_state r_state, n_state;
    t_state r_ret, n_ret;

    // Next state and command decode.
    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        o_op    = chm_pkg::OP_NONE;
        unique case (r_state)
            ST_LOAD: begin
                o_op = chm_pkg::OP_LOAD;
                if (i_stat.acc_last) n_state = ST_SINIT;
            end
            ST_SINIT: begin
                o_op    = chm_pkg::OP_S_INIT;
                n_state = ST_SI;
            end
            ST_SI: begin
                if (i_stat.i_eq_n) begin
                    n_state = ST_H0;
                end else begin
                    o_op    = chm_pkg::OP_S_RDI;
                    n_state = ST_SV;
                end
            end
            ST_SV: begin
                o_op    = chm_pkg::OP_S_LDV;
                n_state = ST_SR;
            end
            ST_SR: begin
                if (i_stat.j_zero) begin
                    n_state = ST_SW;
                end else begin
                    o_op    = chm_pkg::OP_S_RDJ;
                    n_state = ST_SC;
                end
            end
            ST_SC: begin
                if (i_stat.v_before) begin
                    o_op    = chm_pkg::OP_S_SHIFT;
                    n_state = ST_SR;
                end else begin
                    n_state = ST_SW;
                end
            end
            ST_SW: begin
                o_op    = chm_pkg::OP_S_PUTV;
                n_state = ST_SI;
            end
            ST_H0: begin
                o_op    = chm_pkg::OP_H_RD0;
                n_state = ST_H1;
            end
            ST_H1: begin
                o_op    = chm_pkg::OP_H_RDN;
                n_state = ST_H2;
            end
            ST_H2: begin
                o_op    = chm_pkg::OP_H_LDN;
                n_state = ST_HC;
            end
            ST_HC: begin
                if (i_stat.trivial) begin
                    o_op    = chm_pkg::OP_O_EMIT1;
                    n_state = ST_OW1;
                end else begin
                    o_op    = chm_pkg::OP_H_INIT;
                    n_state = ST_HI;
                end
            end
            ST_HI: begin
                if (i_stat.i_eq_n) begin
                    n_state = ST_OU0;
                end else begin
                    o_op    = chm_pkg::OP_H_RDI;
                    n_state = ST_HS;
                end
            end
            ST_HS: begin
                o_op    = chm_pkg::OP_H_SIDE;
                n_ret   = ST_HF;
                n_state = ST_TD;
            end
            ST_HF: begin
                o_op    = chm_pkg::OP_H_FLAGS;
                n_state = ST_UC;
            end
            // Shared orientation sequence, returns to r_ret.
            ST_TD: begin
                o_op    = chm_pkg::OP_T_D;
                n_state = ST_TM1;
            end
            ST_TM1: begin
                o_op    = chm_pkg::OP_T_M1;
                n_state = ST_TM2;
            end
            ST_TM2: begin
                o_op    = chm_pkg::OP_T_M2;
                n_state = r_ret;
            end
            // Fetch the two stack-top points into the operand registers.
            ST_CR1: begin
                o_op    = chm_pkg::OP_C_RD1;
                n_state = ST_CR2;
            end
            ST_CR2: begin
                o_op    = chm_pkg::OP_C_RD2;
                n_state = ST_CR3;
            end
            ST_CR3: begin
                o_op    = chm_pkg::OP_C_RD3;
                n_state = ST_TD;
            end
            ST_UC: begin
                if (!i_stat.do_u) begin
                    n_state = ST_LC;
                end else if (i_stat.nu_ge2) begin
                    o_op    = chm_pkg::OP_U_STK;
                    n_ret   = ST_UT;
                    n_state = ST_CR1;
                end else begin
                    n_state = ST_UP;
                end
            end
            ST_UT: begin
                if (!i_stat.turn_neg) begin
                    o_op    = chm_pkg::OP_U_POP;
                    n_state = ST_UC;
                end else begin
                    n_state = ST_UP;
                end
            end
            ST_UP: begin
                o_op    = chm_pkg::OP_U_PUSH;
                n_state = ST_LC;
            end
            ST_LC: begin
                if (!i_stat.do_l) begin
                    n_state = ST_HN;
                end else if (i_stat.nl_ge2) begin
                    o_op    = chm_pkg::OP_L_STK;
                    n_ret   = ST_LT;
                    n_state = ST_CR1;
                end else begin
                    n_state = ST_LP;
                end
            end
            ST_LT: begin
                if (!i_stat.turn_pos) begin
                    o_op    = chm_pkg::OP_L_POP;
                    n_state = ST_LC;
                end else begin
                    n_state = ST_LP;
                end
            end
            ST_LP: begin
                o_op    = chm_pkg::OP_L_PUSH;
                n_state = ST_HN;
            end
            ST_HN: begin
                o_op    = chm_pkg::OP_H_NEXT;
                n_state = ST_HI;
            end
            // Upper chain output, first to last.
            ST_OU0: begin
                o_op    = chm_pkg::OP_O_INITU;
                n_state = ST_OUS;
            end
            ST_OUS: begin
                o_op    = chm_pkg::OP_O_STKU;
                n_state = ST_OUR;
            end
            ST_OUR: begin
                o_op    = chm_pkg::OP_C_RD1;
                n_state = ST_OUE;
            end
            ST_OUE: begin
                o_op    = chm_pkg::OP_O_EMITU;
                n_state = ST_OUW;
            end
            ST_OUW: begin
                if (!i_stat.out_busy) begin
                    if (i_stat.k_u_end) begin
                        n_state = i_stat.nl_ge3 ? ST_OL0 : ST_DONE;
                    end else begin
                        o_op    = chm_pkg::OP_O_NEXTU;
                        n_state = ST_OUS;
                    end
                end
            end
            // Inner lower chain output, in reverse.
            ST_OL0: begin
                o_op    = chm_pkg::OP_O_INITL;
                n_state = ST_OLS;
            end
            ST_OLS: begin
                o_op    = chm_pkg::OP_O_STKL;
                n_state = ST_OLR;
            end
            ST_OLR: begin
                o_op    = chm_pkg::OP_C_RD1;
                n_state = ST_OLE;
            end
            ST_OLE: begin
                o_op    = chm_pkg::OP_O_EMITL;
                n_state = ST_OLW;
            end
            ST_OLW: begin
                if (!i_stat.out_busy) begin
                    if (i_stat.k_l_end) begin
                        n_state = ST_DONE;
                    end else begin
                        o_op    = chm_pkg::OP_O_NEXTL;
                        n_state = ST_OLS;
                    end
                end
            end
            ST_OW1: begin
                if (!i_stat.out_busy) n_state = ST_DONE;
            end
            ST_DONE: begin
                o_op    = chm_pkg::OP_DONE;
                n_state = ST_LOAD;
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_ret   <= ST_LOAD;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
        end
    end

endmodule

FILE: rtl/core/chm_dp.sv
// ============================================================================
// chm_dp
// Point store, chain stacks, orientation unit, counters and output register.
// ============================================================================
module chm_dp #(
    parameter int MAX_POINTS = chm_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = chm_pkg::COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  chm_pkg::t_op                 i_op,
    output chm_pkg::t_stat               o_stat,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic signed [COORD_BITS-1:0] i_point_x,
    input  logic signed [COORD_BITS-1:0] i_point_y,
    input  logic                         i_last_point,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [COORD_BITS-1:0] o_hull_x,
    output logic signed [COORD_BITS-1:0] o_hull_y,
    output logic                         o_last_vertex,
    output logic                         o_overflow
);

    localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int PB = 2 * COORD_BITS;
    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;
    localparam logic [CW-1:0] C_ZERO = CW'(0);
    localparam logic [CW-1:0] C_ONE  = CW'(1);
    localparam logic [CW-1:0] C_TWO  = CW'(2);
    localparam logic [CW-1:0] C_FULL = CW'(MAX_POINTS);

    // Storage.
    logic [PB-1:0] mem  [MAX_POINTS];
    logic [IW-1:0] ustk [MAX_POINTS];
    logic [IW-1:0] lstk [MAX_POINTS];

    // Counters and flags.
    logic [CW-1:0] r_cnt, r_i, r_j, r_nu, r_nl, r_k;
    logic          r_drop, r_do_u, r_do_l;
    logic [IW-1:0] r_s1, r_s2;

    // Point registers, packed as {x, y}.
    logic [PB-1:0] r_rd, r_v, r_p0, r_pl, r_pi, r_a, r_b, r_c;

    // Orientation unit.
    logic signed [DW-1:0] r_dbx, r_dby, r_dcx, r_dcy;
    logic signed [PW-1:0] r_m1, r_m2;

    // Output register.
    logic                         r_oval, r_olast, r_oovf;
    logic signed [COORD_BITS-1:0] r_ox, r_oy;

    logic          w_accept, w_full, w_we;
    logic [CW-1:0] w_cnt_m1, w_j_m1, w_nu_m1, w_nu_m2, w_nl_m1, w_nl_m2, w_raddr_c;
    logic [IW-1:0] w_raddr, w_waddr;
    logic [PB-1:0] w_wdata;
    logic signed [COORD_BITS-1:0] w_vx, w_vy, w_qx, w_qy;

    assign w_cnt_m1 = r_cnt - C_ONE;
    assign w_j_m1   = r_j - C_ONE;
    assign w_nu_m1  = r_nu - C_ONE;
    assign w_nu_m2  = r_nu - C_TWO;
    assign w_nl_m1  = r_nl - C_ONE;
    assign w_nl_m2  = r_nl - C_TWO;

    assign w_full   = (r_cnt == C_FULL);
    assign w_accept = (i_op == chm_pkg::OP_LOAD) && i_valid;
    assign o_stall  = (i_op != chm_pkg::OP_LOAD);

    // Sort key compare of the held point against the point just read.
    assign w_vx = r_v[PB-1:COORD_BITS];
    assign w_vy = r_v[COORD_BITS-1:0];
    assign w_qx = r_rd[PB-1:COORD_BITS];
    assign w_qy = r_rd[COORD_BITS-1:0];

    // Status back to the controller.
    always_comb begin
        o_stat.acc_last = w_accept && i_last_point;
        o_stat.i_eq_n   = (r_i == r_cnt);
        o_stat.i_is_end = (r_i == w_cnt_m1);
        o_stat.j_zero   = (r_j == C_ZERO);
        o_stat.v_before = (w_vx < w_qx) || ((w_vx == w_qx) && (w_vy < w_qy));
        o_stat.trivial  = (r_cnt == C_ONE) || (r_p0 == r_pl);
        o_stat.do_u     = r_do_u;
        o_stat.do_l     = r_do_l;
        o_stat.nu_ge2   = (r_nu >= C_TWO);
        o_stat.nl_ge2   = (r_nl >= C_TWO);
        o_stat.nl_ge3   = (r_nl > C_TWO);
        o_stat.turn_pos = (r_m1 > r_m2);
        o_stat.turn_neg = (r_m1 < r_m2);
        o_stat.k_u_end  = (r_k == w_nu_m1);
        o_stat.k_l_end  = (r_k == C_ONE);
        o_stat.out_busy = r_oval;
    end

    // Point store read address.
    always_comb begin
        w_raddr_c = C_ZERO;
        w_raddr   = '0;
        unique case (i_op)
            chm_pkg::OP_S_RDI,
            chm_pkg::OP_H_RDI: w_raddr_c = r_i;
            chm_pkg::OP_S_RDJ: w_raddr_c = w_j_m1;
            chm_pkg::OP_H_RDN: w_raddr_c = w_cnt_m1;
            chm_pkg::OP_C_RD1: w_raddr   = r_s1;
            chm_pkg::OP_C_RD2: w_raddr   = r_s2;
            default:           w_raddr_c = C_ZERO;
        endcase
        if (i_op != chm_pkg::OP_C_RD1 && i_op != chm_pkg::OP_C_RD2) begin
            w_raddr = w_raddr_c[IW-1:0];
        end
    end

    // Point store write port.
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_j[IW-1:0];
        w_wdata = r_v;
        unique case (i_op)
            chm_pkg::OP_LOAD: begin
                w_we    = w_accept && !w_full;
                w_waddr = r_cnt[IW-1:0];
                w_wdata = {i_point_x, i_point_y};
            end
            chm_pkg::OP_S_SHIFT: begin
                w_we    = 1'b1;
                w_wdata = r_rd;
            end
            chm_pkg::OP_S_PUTV: begin
                w_we    = 1'b1;
            end
            default: begin
                w_we    = 1'b0;
            end
        endcase
    end

    // Point store.
    always_ff @(posedge i_clk) begin
        if (w_we) mem[w_waddr] <= w_wdata;
        r_rd <= mem[w_raddr];
    end

    // Chain stacks.
    always_ff @(posedge i_clk) begin
        case (i_op)
            chm_pkg::OP_H_INIT: begin
                ustk[0] <= '0;
                lstk[0] <= '0;
            end
            chm_pkg::OP_U_PUSH: ustk[r_nu[IW-1:0]] <= r_i[IW-1:0];
            chm_pkg::OP_L_PUSH: lstk[r_nl[IW-1:0]] <= r_i[IW-1:0];
            chm_pkg::OP_U_STK: begin
                r_s1 <= ustk[w_nu_m2[IW-1:0]];
                r_s2 <= ustk[w_nu_m1[IW-1:0]];
            end
            chm_pkg::OP_L_STK: begin
                r_s1 <= lstk[w_nl_m2[IW-1:0]];
                r_s2 <= lstk[w_nl_m1[IW-1:0]];
            end
            chm_pkg::OP_O_STKU: r_s1 <= ustk[r_k[IW-1:0]];
            chm_pkg::OP_O_STKL: r_s1 <= lstk[r_k[IW-1:0]];
            default: begin
            end
        endcase
    end

    // Orientation of c against the line a-b, as two products compared.
    always_ff @(posedge i_clk) begin
        case (i_op)
            chm_pkg::OP_T_D: begin
                r_dbx <= DW'(signed'(r_b[PB-1:COORD_BITS])) -
                         DW'(signed'(r_a[PB-1:COORD_BITS]));
                r_dby <= DW'(signed'(r_b[COORD_BITS-1:0])) -
                         DW'(signed'(r_a[COORD_BITS-1:0]));
                r_dcx <= DW'(signed'(r_c[PB-1:COORD_BITS])) -
                         DW'(signed'(r_a[PB-1:COORD_BITS]));
                r_dcy <= DW'(signed'(r_c[COORD_BITS-1:0])) -
                         DW'(signed'(r_a[COORD_BITS-1:0]));
            end
            chm_pkg::OP_T_M1: r_m1 <= PW'(r_dbx) * PW'(r_dcy);
            chm_pkg::OP_T_M2: r_m2 <= PW'(r_dby) * PW'(r_dcx);
            default: begin
            end
        endcase
    end

    // Point and operand registers.
    always_ff @(posedge i_clk) begin
        case (i_op)
            chm_pkg::OP_S_LDV: r_v  <= r_rd;
            chm_pkg::OP_H_RDN: r_p0 <= r_rd;
            chm_pkg::OP_H_LDN: r_pl <= r_rd;
            chm_pkg::OP_H_SIDE: begin
                r_pi <= r_rd;
                r_a  <= r_p0;
                r_b  <= r_rd;
                r_c  <= r_pl;
            end
            chm_pkg::OP_C_RD2: r_a <= r_rd;
            chm_pkg::OP_C_RD3: begin
                r_b <= r_rd;
                r_c <= r_pi;
            end
            chm_pkg::OP_H_FLAGS: begin
                r_do_u <= o_stat.i_is_end || (r_m1 < r_m2);
                r_do_l <= o_stat.i_is_end || (r_m1 > r_m2);
            end
            default: begin
            end
        endcase
    end

    // Index counters.
    always_ff @(posedge i_clk) begin
        case (i_op)
            chm_pkg::OP_S_INIT: r_i <= C_ONE;
            chm_pkg::OP_S_LDV:  r_j <= r_i;
            chm_pkg::OP_S_SHIFT: r_j <= w_j_m1;
            chm_pkg::OP_S_PUTV: r_i <= r_i + C_ONE;
            chm_pkg::OP_H_INIT: begin
                r_i  <= C_ONE;
                r_nu <= C_ONE;
                r_nl <= C_ONE;
            end
            chm_pkg::OP_U_POP:  r_nu <= w_nu_m1;
            chm_pkg::OP_U_PUSH: r_nu <= r_nu + C_ONE;
            chm_pkg::OP_L_POP:  r_nl <= w_nl_m1;
            chm_pkg::OP_L_PUSH: r_nl <= r_nl + C_ONE;
            chm_pkg::OP_H_NEXT: r_i  <= r_i + C_ONE;
            chm_pkg::OP_O_INITU: r_k <= C_ZERO;
            chm_pkg::OP_O_NEXTU: r_k <= r_k + C_ONE;
            chm_pkg::OP_O_INITL: r_k <= w_nl_m2;
            chm_pkg::OP_O_NEXTL: r_k <= r_k - C_ONE;
            default: begin
            end
        endcase
    end

    // Fill count and the dropped-point flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= C_ZERO;
            r_drop <= 1'b0;
        end else if (i_op == chm_pkg::OP_DONE) begin
            r_cnt  <= C_ZERO;
            r_drop <= 1'b0;
        end else if (w_accept) begin
            if (w_full) r_drop <= 1'b1;
            else        r_cnt  <= r_cnt + C_ONE;
        end
    end

    // Output register; a request is held until the sink takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oval <= 1'b0;
        end else if (i_op == chm_pkg::OP_O_EMITU || i_op == chm_pkg::OP_O_EMITL ||
                     i_op == chm_pkg::OP_O_EMIT1) begin
            r_oval <= 1'b1;
        end else if (!i_stall) begin
            r_oval <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_op)
            chm_pkg::OP_O_EMITU: begin
                r_ox    <= r_rd[PB-1:COORD_BITS];
                r_oy    <= r_rd[COORD_BITS-1:0];
                r_olast <= (r_nl <= C_TWO) && o_stat.k_u_end;
                r_oovf  <= r_drop;
            end
            chm_pkg::OP_O_EMITL: begin
                r_ox    <= r_rd[PB-1:COORD_BITS];
                r_oy    <= r_rd[COORD_BITS-1:0];
                r_olast <= o_stat.k_l_end;
                r_oovf  <= r_drop;
            end
            chm_pkg::OP_O_EMIT1: begin
                r_ox    <= r_p0[PB-1:COORD_BITS];
                r_oy    <= r_p0[COORD_BITS-1:0];
                r_olast <= 1'b1;
                r_oovf  <= r_drop;
            end
            default: begin
            end
        endcase
    end

    assign o_valid       = r_oval;
    assign o_hull_x      = r_ox;
    assign o_hull_y      = r_oy;
    assign o_last_vertex = r_olast;
    assign o_overflow    = r_oovf;

endmodule

FILE: rtl/core/convex_hull_monotone_chain.sv
// ============================================================================
// convex_hull_monotone_chain
// Convex hull of a point set by the monotone chain method, exact integers.
// ============================================================================
// Points are taken one per cycle while the block is loading; the point flagged
// last_point starts the hull, and no request is taken until every vertex of
// that set has been delivered. The work after the last point is bound by the
// one-read, one-write point store and the one shared orientation unit (two
// products formed in turn and compared): the insertion sort reads, compares
// and shifts one point at a time; each point then gets a side test against
// the line from first to last point, then a check of each chain it joins,
// each check fetching the two stack-top points, a new check after each pop;
// each vertex is read from its stack and waits out any stall. Hull vertices
// come out as the upper chain from left to right, then the inner lower chain
// from right to left, with last_vertex on the final one and overflow set on
// every vertex of a set that lost points beyond MAX_POINTS.
module convex_hull_monotone_chain #(
    parameter int MAX_POINTS = chm_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = chm_pkg::COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic signed [COORD_BITS-1:0] i_point_x,
    input  logic signed [COORD_BITS-1:0] i_point_y,
    input  logic                         i_last_point,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [COORD_BITS-1:0] o_hull_x,
    output logic signed [COORD_BITS-1:0] o_hull_y,
    output logic                         o_last_vertex,
    output logic                         o_overflow
);

    chm_pkg::t_op   w_op;
    chm_pkg::t_stat w_stat;

    // Sequencer.
    chm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_op    (w_op)
    );

    // Storage and arithmetic.
    chm_dp #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_op          (w_op),
        .o_stat        (w_stat),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_point_x     (i_point_x),
        .i_point_y     (i_point_y),
        .i_last_point  (i_last_point),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_hull_x      (o_hull_x),
        .o_hull_y      (o_hull_y),
        .o_last_vertex (o_last_vertex),
        .o_overflow    (o_overflow)
    );

endmodule
